FILE: sv/scme_pkg.sv
// ----------------------------------------------------------------------------
// scme_pkg
// shared constants and types for the span clip mask engine
// ----------------------------------------------------------------------------
`default_nettype none
package scme_pkg;
  localparam int SPAN_DEPTH_DEF    = 4096;
  localparam int ROW_DEPTH_DEF     = 1024;
  localparam int MAX_ROW_SPANS_DEF = 255;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_FIN   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] ZONE_TOP    = 2'd0;
  localparam logic [1:0] ZONE_RECT   = 2'd1;
  localparam logic [1:0] ZONE_BOTTOM = 2'd2;

  localparam logic [1:0] ANS_OUT  = 2'd0;
  localparam logic [1:0] ANS_IN   = 2'd1;
  localparam logic [1:0] ANS_PART = 2'd2;

  localparam logic [7:0] FULL_COVER = 8'd255;
  localparam logic signed [17:0] SAT_MAX = 18'sd32767;

  // x + len reaches 98302, so run ends need 18 signed bits
  typedef logic signed [17:0] wide_t;
endpackage
`default_nettype wire

FILE: sv/scme_span_cmp.sv
// ----------------------------------------------------------------------------
// scme_span_cmp
// shared interval compare unit: one span against one run per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module scme_span_cmp (
  input  wire logic signed [17:0] run_l,
  input  wire logic signed [17:0] run_r,
  input  wire logic signed [15:0] span_x,
  input  wire logic [15:0]        span_len,
  output logic                    hit,
  output logic                    stick_out
);
  import scme_pkg::*;
  logic signed [17:0] sl;
  logic signed [17:0] sr;
  logic signed [17:0] rl;
  logic signed [17:0] rr;
  // 18 bit compare keeps wide ends exact
  always_comb begin
    sl = 18'(span_x);
    sr = 18'(span_x) + $signed({2'b00, span_len});
    rl = run_l;
    rr = run_r;
    hit = (rl < sr) && (rr > sl);
    stick_out = (rl < sl) || (rr > sr);
  end
endmodule
`default_nettype wire

FILE: sv/span_clip_mask_engine_top.sv
// ----------------------------------------------------------------------------
// span_clip_mask_engine_top
// clip mask builder with rectangle zone, corner row table and run queries
// ----------------------------------------------------------------------------
// channel | dir | ports
// in      | in  | in_valid in_ready in_command in_pos_x in_pos_y in_extent ...
// out     | out | out_valid out_ready out_overlap out_mask_empty out_status
//
// add, clear, finalize and rectangle queries pass from accept through exec to out
// corner scans run ROWRD and ROWCK per row read and SPRD and SPCK per span tested,
// all through a single row table read port and a single span compare unit
// a cursor past the queried y costs one more row read from the window start
// in_ready is low while an item is at work or its result waits in out,
// so a new beat is accepted only once the last result has been taken
// reset and clear both empty the mask; memories need no clearing pass
`default_nettype none
module span_clip_mask_engine_top #(
  parameter int SPAN_DEPTH    = scme_pkg::SPAN_DEPTH_DEF,
  parameter int ROW_DEPTH     = scme_pkg::ROW_DEPTH_DEF,
  parameter int MAX_ROW_SPANS = scme_pkg::MAX_ROW_SPANS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic [15:0]        in_extent,
  input  wire logic [7:0]         in_coverage,
  input  wire logic [7:0]         in_row_span_count,
  input  wire logic               in_row_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_overlap,
  output logic                    out_mask_empty,
  output logic                    out_status
);
  import scme_pkg::*;

  localparam int SAW = $clog2(SPAN_DEPTH);
  localparam int SCW = $clog2(SPAN_DEPTH + 1);
  localparam int RAW = $clog2(ROW_DEPTH);
  localparam int RCW = $clog2(ROW_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ROWRD = 3'd2;
  localparam logic [2:0] S_ROWCK = 3'd3;
  localparam logic [2:0] S_SPRD  = 3'd4;
  localparam logic [2:0] S_SPCK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // memories
  logic [31:0]           pool_mem [SPAN_DEPTH];
  logic [SCW+16+8-1:0]   row_mem  [ROW_DEPTH];
  logic [31:0]           pool_q;
  logic [SCW+16+8-1:0]   row_q;

  logic [2:0]            state_r, state_nxt;
  logic [SCW-1:0]        spans_used_r, spans_used_nxt;
  logic [RCW-1:0]        rows_used_r, rows_used_nxt;
  logic [RCW-1:0]        bottom_start_r, bottom_start_nxt;
  logic [1:0]            zone_r, zone_nxt;
  logic signed [15:0]    rect_top_r, rect_top_nxt;
  logic signed [15:0]    rect_bottom_r, rect_bottom_nxt;
  logic signed [15:0]    rect_left_r, rect_left_nxt;
  logic signed [15:0]    rect_right_r, rect_right_nxt;
  logic [RCW-1:0]        top_cursor_r, top_cursor_nxt;
  logic [RCW-1:0]        bottom_cursor_r, bottom_cursor_nxt;
  logic [SCW-1:0]        row_span_base_r, row_span_base_nxt;

  // latched item
  logic [1:0]            cmd_r;
  logic signed [15:0]    x_r, y_r;
  logic [15:0]           len_r;
  logic [7:0]            cov_r;
  logic                  last_r;

  // scan context
  logic                  use_bot_r, use_bot_nxt;
  logic [RCW-1:0]        ri_r, ri_nxt;
  logic [RCW-1:0]        rend_r, rend_nxt;
  logic [SCW:0]          sk_r, sk_nxt;
  logic [8:0]            sj_r, sj_nxt;
  logic [7:0]            scnt_r, scnt_nxt;
  logic                  any_in_r, any_in_nxt, any_out_r, any_out_nxt;

  logic [1:0]            ovl_r, ovl_nxt;
  logic                  st_r, st_nxt;
  logic                  ov_r, ov_nxt;

  logic                  pool_we, row_we;
  logic [SAW-1:0]        pool_wa, pool_ra;
  logic [RAW-1:0]        row_wa, row_ra;
  logic [31:0]           pool_wd;
  logic [SCW+16+8-1:0]   row_wd;

  wide_t                 run_r_end;
  wide_t                 run_l_ext;
  logic                  cmp_hit, cmp_out;

  logic [SCW-1:0]        row_q_off;
  logic signed [15:0]    row_q_y;
  logic [7:0]            row_q_cnt;

  assign row_q_off = row_q[SCW+24-1:24];
  assign row_q_y   = $signed(row_q[23:8]);
  assign row_q_cnt = row_q[7:0];

  assign run_l_ext = 18'(x_r);
  assign run_r_end = 18'(x_r) + $signed({2'b00, len_r});

  scme_span_cmp u_cmp (
    .run_l    (run_l_ext),
    .run_r    (run_r_end),
    .span_x   ($signed(pool_q[31:16])),
    .span_len (pool_q[15:0]),
    .hit      (cmp_hit),
    .stick_out(cmp_out)
  );

  // memory ports
  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_wa] <= pool_wd;
    end
    pool_q <= pool_mem[pool_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    row_q <= row_mem[row_ra];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_overlap = ovl_r;
  assign out_status  = st_r;
  assign out_mask_empty = (rows_used_r == '0) && (rect_top_r == rect_bottom_r);

  // sequencer
  always_comb begin
    logic [SCW-1:0]     held;
    wide_t              right_w, bot_w;
    logic signed [15:0] right_s, bot_s;
    logic               active;
    logic [RCW-1:0]     st_i, en_i, cur_i;
    held     = spans_used_r - row_span_base_r;
    right_w  = run_r_end;
    right_s  = (right_w > SAT_MAX) ? 16'sh7fff : right_w[15:0];
    bot_w    = 18'(y_r) + 18'sd1;
    bot_s    = (bot_w > SAT_MAX) ? 16'sh7fff : bot_w[15:0];
    active   = rect_top_r < rect_bottom_r;
    st_i     = '0;
    en_i     = '0;
    cur_i    = '0;

    state_nxt = state_r;
    spans_used_nxt = spans_used_r;
    rows_used_nxt = rows_used_r;
    bottom_start_nxt = bottom_start_r;
    zone_nxt = zone_r;
    rect_top_nxt = rect_top_r;
    rect_bottom_nxt = rect_bottom_r;
    rect_left_nxt = rect_left_r;
    rect_right_nxt = rect_right_r;
    top_cursor_nxt = top_cursor_r;
    bottom_cursor_nxt = bottom_cursor_r;
    row_span_base_nxt = row_span_base_r;
    use_bot_nxt = use_bot_r;
    ri_nxt = ri_r;
    rend_nxt = rend_r;
    sk_nxt = sk_r;
    sj_nxt = sj_r;
    scnt_nxt = scnt_r;
    any_in_nxt = any_in_r;
    any_out_nxt = any_out_r;
    ovl_nxt = ovl_r;
    st_nxt = st_r;
    ov_nxt = ov_r;
    pool_we = 1'b0;
    row_we = 1'b0;
    pool_wa = spans_used_r[SAW-1:0];
    pool_wd = {x_r, len_r};
    row_wa = rows_used_r[RAW-1:0];
    row_wd = {row_span_base_r, y_r, 8'(spans_used_r - row_span_base_r + 1'b1)};
    row_ra = ri_r[RAW-1:0];
    pool_ra = sk_r[SAW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ovl_nxt = ANS_OUT;
        st_nxt = 1'b0;
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_CLEAR: begin
            spans_used_nxt = '0;
            rows_used_nxt = '0;
            bottom_start_nxt = '0;
            zone_nxt = ZONE_TOP;
            rect_top_nxt = '0;
            rect_bottom_nxt = '0;
            rect_left_nxt = '0;
            rect_right_nxt = '0;
            top_cursor_nxt = '0;
            bottom_cursor_nxt = '0;
            row_span_base_nxt = '0;
          end
          CMD_FIN: begin
            if (zone_r == ZONE_RECT) begin
              bottom_start_nxt = rows_used_r;
            end
          end
          CMD_ADD: begin
            if (last_r && held == '0 && cov_r == FULL_COVER &&
                zone_r == ZONE_TOP) begin
              rect_left_nxt = x_r;
              rect_right_nxt = right_s;
              rect_top_nxt = y_r;
              rect_bottom_nxt = bot_s;
              zone_nxt = ZONE_RECT;
            end else if (last_r && held == '0 && cov_r == FULL_COVER &&
                         zone_r == ZONE_RECT && x_r == rect_left_r &&
                         right_s == rect_right_r) begin
              rect_bottom_nxt = bot_s;
            end else if (32'(spans_used_r) >= SPAN_DEPTH ||
                         32'(held) >= MAX_ROW_SPANS) begin
              st_nxt = 1'b1;
            end else begin
              pool_we = 1'b1;
              spans_used_nxt = spans_used_r + 1'b1;
              if (last_r) begin
                if (zone_r == ZONE_RECT) begin
                  bottom_start_nxt = rows_used_r;
                  zone_nxt = ZONE_BOTTOM;
                end
                if (32'(rows_used_r) >= ROW_DEPTH) begin
                  spans_used_nxt = row_span_base_r;
                  st_nxt = 1'b1;
                end else begin
                  row_we = 1'b1;
                  rows_used_nxt = rows_used_r + 1'b1;
                  row_span_base_nxt = spans_used_r + 1'b1;
                end
              end
            end
          end
          default: begin
            // query run overlap
            if (active && y_r >= rect_top_r && y_r < rect_bottom_r) begin
              if (run_l_ext >= 18'(rect_right_r) || run_r_end <= 18'(rect_left_r))
                ovl_nxt = ANS_OUT;
              else if (run_l_ext >= 18'(rect_left_r) && run_r_end <= 18'(rect_right_r))
                ovl_nxt = ANS_IN;
              else
                ovl_nxt = ANS_PART;
            end else begin
              if (active && y_r >= rect_top_r) begin
                st_i = bottom_start_r;
                en_i = rows_used_r;
                cur_i = bottom_cursor_r;
                use_bot_nxt = 1'b1;
              end else begin
                st_i = '0;
                en_i = active ? bottom_start_r : rows_used_r;
                cur_i = top_cursor_r;
                use_bot_nxt = 1'b0;
              end
              if (en_i > rows_used_r) en_i = rows_used_r;
              if (st_i > en_i) st_i = en_i;
              rend_nxt = en_i;
              // cursor restart when out of window; y check happens on first read
              if (cur_i < st_i || cur_i >= en_i) begin
                cur_i = st_i;
                if (use_bot_nxt) bottom_cursor_nxt = st_i;
                else top_cursor_nxt = st_i;
              end
              ri_nxt = cur_i;
              // window start kept in sk for a restart; sj[0] marks that the
              // first row read must check whether the cursor row lies past y
              sk_nxt = {1'b0, SCW'(st_i)};
              sj_nxt = {8'd0, (cur_i != st_i)};
              if (cur_i >= en_i) begin
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_ROWRD;
              end
            end
          end
        endcase
      end
      S_ROWRD: begin
        row_ra = ri_r[RAW-1:0];
        state_nxt = S_ROWCK;
      end
      S_ROWCK: begin
        if (sj_r[0] && row_q_y > y_r) begin
          // cursor row past y: restart at window start
          sj_nxt[0] = 1'b0;
          ri_nxt = RCW'(sk_r[SCW-1:0]);
          if (use_bot_r) bottom_cursor_nxt = RCW'(sk_r[SCW-1:0]);
          else top_cursor_nxt = RCW'(sk_r[SCW-1:0]);
          state_nxt = S_ROWRD;
        end else if (row_q_y > y_r) begin
          state_nxt = S_OUT;
        end else if (row_q_y == y_r) begin
          if (use_bot_r) bottom_cursor_nxt = ri_r;
          else top_cursor_nxt = ri_r;
          sk_nxt = {1'b0, row_q_off};
          scnt_nxt = row_q_cnt;
          sj_nxt = '0;
          any_in_nxt = 1'b0;
          any_out_nxt = 1'b0;
          state_nxt = S_SPRD;
        end else begin
          sj_nxt[0] = 1'b0;
          ri_nxt = ri_r + 1'b1;
          if (ri_r + 1'b1 >= rend_r) state_nxt = S_OUT;
          else state_nxt = S_ROWRD;
        end
      end
      S_SPRD: begin
        if (sj_r[7:0] >= scnt_r || 32'(sk_r) >= SPAN_DEPTH) begin
          ovl_nxt = !any_in_r ? ANS_OUT : (any_out_r ? ANS_PART : ANS_IN);
          state_nxt = S_OUT;
        end else begin
          pool_ra = sk_r[SAW-1:0];
          state_nxt = S_SPCK;
        end
      end
      S_SPCK: begin
        if (cmp_hit) begin
          any_in_nxt = 1'b1;
          if (cmp_out) any_out_nxt = 1'b1;
        end
        sk_nxt = sk_r + 1'b1;
        sj_nxt = sj_r + 1'b1;
        state_nxt = S_SPRD;
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
        end else if (out_ready) begin
          ov_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // item capture, scan context and result registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      x_r <= in_pos_x;
      y_r <= in_pos_y;
      len_r <= in_extent;
      cov_r <= in_coverage;
      last_r <= in_row_last;
    end
    use_bot_r <= use_bot_nxt;
    ri_r <= ri_nxt;
    rend_r <= rend_nxt;
    sk_r <= sk_nxt;
    sj_r <= sj_nxt;
    scnt_r <= scnt_nxt;
    any_in_r <= any_in_nxt;
    any_out_r <= any_out_nxt;
    ovl_r <= ovl_nxt;
    st_r <= st_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      spans_used_r <= '0;
      rows_used_r <= '0;
      bottom_start_r <= '0;
      zone_r <= ZONE_TOP;
      rect_top_r <= '0;
      rect_bottom_r <= '0;
      rect_left_r <= '0;
      rect_right_r <= '0;
      top_cursor_r <= '0;
      bottom_cursor_r <= '0;
      row_span_base_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      spans_used_r <= spans_used_nxt;
      rows_used_r <= rows_used_nxt;
      bottom_start_r <= bottom_start_nxt;
      zone_r <= zone_nxt;
      rect_top_r <= rect_top_nxt;
      rect_bottom_r <= rect_bottom_nxt;
      rect_left_r <= rect_left_nxt;
      rect_right_r <= rect_right_nxt;
      top_cursor_r <= top_cursor_nxt;
      bottom_cursor_r <= bottom_cursor_nxt;
      row_span_base_r <= row_span_base_nxt;
    end
  end

  logic unused_ok;
  assign unused_ok = ^in_row_span_count;
endmodule
`default_nettype wire

FILE: sv/scme_checker.sv
// ----------------------------------------------------------------------------
// scme_checker
// port level checks for the span clip mask engine
// ----------------------------------------------------------------------------
`default_nettype none
module scme_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_overlap,
  input wire logic       out_status
);
  // overlap code is never the unused value
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overlap != 2'd3)) else $error("bad overlap code");
  // no new beat while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");
  // accepted beat drops ready next cycle
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  // pending result stays valid with a stable status until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("result dropped");
endmodule

bind span_clip_mask_engine_top scme_checker u_scme_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_overlap(out_overlap),
  .out_status(out_status)
);
`default_nettype wire
